>>> hdl/mas_pkg.sv
// shared types and constants for the macro argument splitter
`default_nettype none
package mas_pkg;

  localparam int MAX_DEPTH = 255;
  localparam int DEPTH_W   = $clog2(MAX_DEPTH + 1);

  localparam logic [7:0] CH_OPEN   = 8'h28;
  localparam logic [7:0] CH_CLOSE  = 8'h29;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_BSLASH = 8'h5C;

  localparam logic [DEPTH_W-1:0] DEPTH_MAX = DEPTH_W'(MAX_DEPTH);

  typedef struct packed {
    logic [DEPTH_W-1:0] paren_depth;
    logic               in_string;
    logic               in_char_literal;
    logic               escape_pending;
    logic               arg_has_text;
    logic               list_has_args;
  } scan_state_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       line_end;
  } scan_item_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       keep_char;
    logic [1:0] args_closed;
    logic       list_closed;
    logic       ended_open;
    logic       depth_overflow;
  } scan_result_t;

endpackage
`default_nettype wire

>>> hdl/mas_scan.sv
// per-byte classification and next scanner state
`default_nettype none
module mas_scan import mas_pkg::*; (
  input  scan_state_t  state_cur,
  input  scan_item_t   item,
  output scan_state_t  state_nxt,
  output scan_result_t result
);

  logic        keep;
  logic        ovf;
  logic        list_done;
  logic        comma_top;
  logic [1:0]  closed;
  scan_state_t mid;

  always_comb begin
    mid       = state_cur;
    keep      = 1'b0;
    ovf       = 1'b0;
    list_done = 1'b0;
    comma_top = 1'b0;
    if (state_cur.escape_pending) begin
      mid.escape_pending = 1'b0;
      keep = 1'b1;
    end else if (state_cur.in_string || state_cur.in_char_literal) begin
      keep = 1'b1;
      if ((state_cur.in_string && item.ch == CH_DQUOTE) ||
          (!state_cur.in_string && item.ch == CH_SQUOTE)) begin
        mid.in_string       = 1'b0;
        mid.in_char_literal = 1'b0;
      end else if (item.ch == CH_BSLASH) begin
        mid.escape_pending = 1'b1;
      end
    end else if (item.ch == CH_OPEN) begin
      keep = 1'b1;
      if (state_cur.paren_depth < DEPTH_MAX) begin
        mid.paren_depth = state_cur.paren_depth + DEPTH_W'(1);
      end else begin
        ovf = 1'b1;
      end
    end else if (item.ch == CH_CLOSE) begin
      if (state_cur.paren_depth == '0) begin
        list_done = 1'b1;
      end else begin
        mid.paren_depth = state_cur.paren_depth - DEPTH_W'(1);
        keep = 1'b1;
      end
    end else if (item.ch == CH_COMMA && state_cur.paren_depth == '0) begin
      comma_top         = 1'b1;
      mid.arg_has_text  = 1'b0;
      mid.list_has_args = 1'b1;
    end else begin
      keep = 1'b1;
      if (item.ch == CH_DQUOTE) begin
        mid.in_string = 1'b1;
      end else if (item.ch == CH_SQUOTE) begin
        mid.in_char_literal = 1'b1;
      end
    end

    if (keep) begin
      mid.arg_has_text = 1'b1;
    end

    closed = {1'b0, list_done | comma_top};
    if (!list_done && item.line_end && (mid.arg_has_text || mid.list_has_args)) begin
      closed = closed + 2'd1;
    end

    // close or line end drop everything back to reset
    if (list_done || item.line_end) begin
      state_nxt = '0;
    end else begin
      state_nxt = mid;
    end

    result.out_char       = item.ch;
    result.keep_char      = keep;
    result.args_closed    = closed;
    result.list_closed    = list_done;
    result.ended_open     = !list_done && item.line_end;
    result.depth_overflow = ovf;
  end

endmodule
`default_nettype wire

>>> hdl/macro_argument_splitter.sv
// top level of the macro argument splitter: input register, scanner, result register
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+--------------------------------------
//   in_     | input     | in_valid / in_stall  | in_ch, in_line_end
//   out_    | output    | out_valid / out_stall| out_char, out_keep_char, out_args_closed,
//           |           |                      | out_list_closed, out_ended_open,
//           |           |                      | out_depth_overflow
//
// one item per cycle sustained while out_stall is low; each item passes from the input
// register into the result register, where its result holds until the receiver takes it
// the scanner state (depth counter and literal flags) updates as an item moves from
// the input register into the result register, so back-to-back items see each other
// a stalled result register holds; the input register then fills and raises in_stall
// synchronous active-low reset clears the valid bits and the scanner state
`default_nettype none
module macro_argument_splitter import mas_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_ch,
  input  wire logic       in_line_end,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_char,
  output logic            out_keep_char,
  output logic [1:0]      out_args_closed,
  output logic            out_list_closed,
  output logic            out_ended_open,
  output logic            out_depth_overflow
);

  // input register
  logic         s1_valid_r;
  scan_item_t   s1_item_r;
  // result register
  logic         s2_valid_r;
  scan_result_t s2_res_r;
  // scanner state
  scan_state_t  state_r;
  scan_state_t  state_nxt;
  scan_result_t res_nxt;

  logic s2_load;
  logic s1_load;

  // result register frees when empty or when its item is taken
  assign s2_load  = s1_valid_r && (!s2_valid_r || !out_stall);
  // input register takes a new item when empty or when its item moves on
  assign in_stall = s1_valid_r && !s2_load;
  assign s1_load  = in_valid && !in_stall;

  mas_scan u_scan (
    .state_cur (state_r),
    .item      (s1_item_r),
    .state_nxt (state_nxt),
    .result    (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      state_r    <= '0;
    end else begin
      if (s1_load) begin
        s1_valid_r <= 1'b1;
      end else if (s2_load) begin
        s1_valid_r <= 1'b0;
      end
      if (s2_load) begin
        s2_valid_r <= 1'b1;
        state_r    <= state_nxt;
      end else if (!out_stall) begin
        s2_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_item_r.ch       <= in_ch;
      s1_item_r.line_end <= in_line_end;
    end
    if (s2_load) begin
      s2_res_r <= res_nxt;
    end
  end

  assign out_valid          = s2_valid_r;
  assign out_char           = s2_res_r.out_char;
  assign out_keep_char      = s2_res_r.keep_char;
  assign out_args_closed    = s2_res_r.args_closed;
  assign out_list_closed    = s2_res_r.list_closed;
  assign out_ended_open     = s2_res_r.ended_open;
  assign out_depth_overflow = s2_res_r.depth_overflow;

  // a closed list or a line end leaves the scanner at reset
  a_clear_after_end: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_load && (res_nxt.list_closed || res_nxt.ended_open)) |=> (state_r == '0))
    else $error("scanner state not cleared after list end");

  // closing paren is dropped and completes exactly one argument
  a_close_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_list_closed) |->
      (!out_keep_char && out_args_closed == 2'd1 && !out_ended_open))
    else $error("malformed list close result");

  // overflow only on a kept open paren at saturated depth
  a_ovf_depth: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_load && res_nxt.depth_overflow) |->
      (res_nxt.keep_char && state_r.paren_depth == DEPTH_MAX))
    else $error("overflow below maximum depth");

  // never three arguments from one byte
  a_args_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_args_closed != 2'd3))
    else $error("args_closed out of range");

endmodule
`default_nettype wire

>>> dv/tb_macro_argument_splitter.sv
// self-checking testbench for the macro argument splitter: directed table, then random text
module tb_macro_argument_splitter;
  timeunit 1ns;
  timeprecision 1ps;
  import mas_pkg::*;

  // ---------------------------------------------------------------------------
  // clock, reset and block ports
  // ---------------------------------------------------------------------------
  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_ch = 8'h00;
  logic       in_line_end = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_char;
  logic       out_keep_char;
  logic [1:0] out_args_closed;
  logic       out_list_closed;
  logic       out_ended_open;
  logic       out_depth_overflow;

  // 10 ns period
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  macro_argument_splitter u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_ch             (in_ch),
    .in_line_end       (in_line_end),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_char          (out_char),
    .out_keep_char     (out_keep_char),
    .out_args_closed   (out_args_closed),
    .out_list_closed   (out_list_closed),
    .out_ended_open    (out_ended_open),
    .out_depth_overflow(out_depth_overflow)
  );

  // ---------------------------------------------------------------------------
  // directed table: one row per item
  // the expected result is typed in only where it is obvious (after reset, list
  // closes, line ends, error-ish corners); other rows take the boundary tracker
  // ---------------------------------------------------------------------------
  typedef struct {
    scan_item_t   item;
    bit           pinned;
    scan_result_t want;
  } dir_row_t;

  localparam int           NUM_DIR = 25;
  localparam scan_result_t NO_PIN  = '0;

  dir_row_t dir_rows [NUM_DIR] = '{
    // empty list right after reset: close ends one (empty) argument and the list
    '{'{CH_CLOSE, 1'b0}, 1'b1, '{CH_CLOSE, 1'b0, 2'd1, 1'b1, 1'b0, 1'b0}},
    '{'{8'h61, 1'b0}, 1'b1, '{8'h61, 1'b1, 2'd0, 1'b0, 1'b0, 1'b0}},
    // top-level comma is dropped and closes an argument
    '{'{CH_COMMA, 1'b0}, 1'b1, '{CH_COMMA, 1'b0, 2'd1, 1'b0, 1'b0, 1'b0}},
    // nested group: comma and close stay in the argument
    '{'{CH_OPEN, 1'b0}, 1'b0, NO_PIN},
    '{'{CH_COMMA, 1'b0}, 1'b0, NO_PIN},
    '{'{CH_CLOSE, 1'b0}, 1'b0, NO_PIN},
    // string literal with comma and an escaped quote inside
    '{'{CH_DQUOTE, 1'b0}, 1'b0, NO_PIN},
    '{'{CH_COMMA, 1'b0}, 1'b0, NO_PIN},
    '{'{CH_BSLASH, 1'b0}, 1'b0, NO_PIN},
    '{'{CH_DQUOTE, 1'b0}, 1'b0, NO_PIN},
    '{'{CH_DQUOTE, 1'b0}, 1'b0, NO_PIN},
    // char literal hiding a close paren
    '{'{CH_SQUOTE, 1'b0}, 1'b0, NO_PIN},
    '{'{CH_CLOSE, 1'b0}, 1'b0, NO_PIN},
    '{'{CH_SQUOTE, 1'b0}, 1'b0, NO_PIN},
    // backslash outside any literal is an ordinary byte
    '{'{CH_BSLASH, 1'b0}, 1'b0, NO_PIN},
    // close on the last byte of the line: list closed, not open
    '{'{CH_CLOSE, 1'b1}, 1'b1, '{CH_CLOSE, 1'b0, 2'd1, 1'b1, 1'b0, 1'b0}},
    // single byte then line end: one argument, left open
    '{'{8'hFF, 1'b1}, 1'b1, '{8'hFF, 1'b1, 2'd1, 1'b0, 1'b1, 1'b0}},
    '{'{8'h00, 1'b0}, 1'b0, NO_PIN},
    // comma as the last byte closes two arguments
    '{'{CH_COMMA, 1'b1}, 1'b1, '{CH_COMMA, 1'b0, 2'd2, 1'b0, 1'b1, 1'b0}},
    // line end with an escape pending inside a string
    '{'{CH_DQUOTE, 1'b0}, 1'b0, NO_PIN},
    '{'{CH_BSLASH, 1'b1}, 1'b1, '{CH_BSLASH, 1'b1, 2'd1, 1'b0, 1'b1, 1'b0}},
    // line end inside a char literal
    '{'{CH_SQUOTE, 1'b0}, 1'b0, NO_PIN},
    '{'{8'h80, 1'b1}, 1'b0, NO_PIN},
    '{'{8'h7F, 1'b0}, 1'b0, NO_PIN},
    '{'{CH_CLOSE, 1'b0}, 1'b0, NO_PIN}
  };

  // sender idle and receiver stall rates per phase, in percent
  localparam int SEND_IDLE [3] = '{29, 53, 0};
  localparam int RECV_IDLE [3] = '{53, 29, 0};

  // ---------------------------------------------------------------------------
  // boundary tracker: mirror of the scanner state and the expected results
  // ---------------------------------------------------------------------------
  scan_state_t  scan = '0;
  scan_result_t expected_results [$];
  scan_result_t head_result;
  scan_item_t   text_q [$];
  string        plain_chars = "abcxyzXYZ0189_ +-*/<>=;.#";

  int send_pct = 0;
  int recv_pct = 0;
  int n_items = 0;
  int n_results = 0;
  int n_args = 0;
  int n_lists = 0;
  int n_open = 0;
  int n_ovf = 0;
  int n_errors = 0;

  // one byte through the tracker; updates scan and returns the result it causes
  function automatic scan_result_t split_step(input logic [7:0] c, input logic last);
    scan_result_t r;
    r = '0;
    r.out_char = c;
    if (scan.escape_pending) begin
      // escaped byte is kept whatever it is
      scan.escape_pending = 1'b0;
      r.keep_char = 1'b1;
    end else if (scan.in_string || scan.in_char_literal) begin
      r.keep_char = 1'b1;
      if (c == (scan.in_string ? CH_DQUOTE : CH_SQUOTE)) begin
        scan.in_string = 1'b0;
        scan.in_char_literal = 1'b0;
      end else if (c == CH_BSLASH) begin
        scan.escape_pending = 1'b1;
      end
    end else if (c == CH_OPEN) begin
      r.keep_char = 1'b1;
      // depth saturates and flags the byte
      if (scan.paren_depth == DEPTH_MAX) r.depth_overflow = 1'b1;
      else scan.paren_depth++;
    end else if (c == CH_CLOSE) begin
      if (scan.paren_depth == 0) begin
        r.args_closed = 2'd1;
        r.list_closed = 1'b1;
      end else begin
        scan.paren_depth--;
        r.keep_char = 1'b1;
      end
    end else if (c == CH_COMMA && scan.paren_depth == 0) begin
      r.args_closed = 2'd1;
      scan.arg_has_text = 1'b0;
      scan.list_has_args = 1'b1;
    end else begin
      r.keep_char = 1'b1;
      if (c == CH_DQUOTE) scan.in_string = 1'b1;
      else if (c == CH_SQUOTE) scan.in_char_literal = 1'b1;
    end

    if (r.keep_char) scan.arg_has_text = 1'b1;

    if (r.list_closed) begin
      scan = '0;
    end else if (last) begin
      // line ran out before the close: flush a pending argument
      if (scan.arg_has_text || scan.list_has_args) r.args_closed++;
      r.ended_open = 1'b1;
      scan = '0;
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // sender: called at a falling edge, returns at the falling edge after acceptance
  // ---------------------------------------------------------------------------
  task automatic send_item(input scan_item_t it, input bit pinned, input scan_result_t want);
    scan_result_t res;
    while ($urandom_range(0, 99) < send_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    in_ch       <= it.ch;
    in_line_end <= it.line_end;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    res = split_step(it.ch, it.line_end);
    expected_results.insert(expected_results.size(), pinned ? want : res);
    n_items++;
    @(negedge clk);
  endtask

  // sender holds off until every expected result is out
  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (expected_results.size() != 0);
  endtask

  task automatic send_text();
    foreach (text_q[i]) send_item(text_q[i], 1'b0, NO_PIN);
  endtask

  // ---------------------------------------------------------------------------
  // text generators
  // ---------------------------------------------------------------------------
  task automatic put_byte(input logic [7:0] c);
    text_q.insert(text_q.size(), {c, 1'b0});
  endtask

  // quoted literal with commas, parens, the other quote and escapes inside
  task automatic add_literal(input logic [7:0] quote);
    put_byte(quote);
    repeat ($urandom_range(0, 5)) begin
      case ($urandom_range(0, 5))
        0: begin
          put_byte(CH_BSLASH);
          put_byte(8'($urandom_range(0, 255)));
        end
        1: put_byte(CH_COMMA);
        2: put_byte($urandom_range(0, 1) ? CH_OPEN : CH_CLOSE);
        3: put_byte(quote == CH_DQUOTE ? CH_SQUOTE : CH_DQUOTE);
        default: put_byte(plain_chars[$urandom_range(0, plain_chars.len() - 1)]);
      endcase
    end
    put_byte(quote);
  endtask

  // argument list with balanced nesting up to five deep; some lines end on the
  // close, some are cut short anywhere (even inside a literal), the rest run on
  task automatic build_list();
    int depth;
    int cut;
    int ending;
    text_q.delete();
    depth = 0;
    repeat ($urandom_range(0, 14)) begin
      case ($urandom_range(0, 11))
        4: if (depth < 5) begin
          put_byte(CH_OPEN);
          depth++;
        end
        5: if (depth > 0) begin
          put_byte(CH_CLOSE);
          depth--;
        end
        6, 7: put_byte(CH_COMMA);
        8: add_literal(CH_DQUOTE);
        9: add_literal(CH_SQUOTE);
        10: put_byte(CH_BSLASH);
        default: put_byte(plain_chars[$urandom_range(0, plain_chars.len() - 1)]);
      endcase
    end
    repeat (depth + 1) put_byte(CH_CLOSE);
    ending = $urandom_range(0, 9);
    if (ending < 4) begin
      text_q[$].line_end = 1'b1;
    end else if (ending < 7) begin
      cut = $urandom_range(0, text_q.size() - 1);
      text_q = text_q[0:cut];
      text_q[$].line_end = 1'b1;
    end
  endtask

  // raw bytes, any value, occasional line ends
  task automatic build_noise();
    text_q.delete();
    repeat ($urandom_range(1, 20))
      text_q.insert(text_q.size(),
                    {8'($urandom_range(0, 255)), 1'($urandom_range(0, 7) == 0)});
  endtask

  // nesting past the counter: two opens saturate, so the list closes two
  // closes early and the leftovers arrive as empty lists
  task automatic build_deep();
    text_q.delete();
    repeat (MAX_DEPTH + 2) put_byte(CH_OPEN);
    put_byte(8'h78);
    repeat (MAX_DEPTH + 3) put_byte(CH_CLOSE);
  endtask

  // ---------------------------------------------------------------------------
  // receiver: random stall, changed at the falling edge only
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    out_stall <= rst_n && ($urandom_range(0, 99) < recv_pct);
  end

  task automatic cmp_field(input string what, input logic [7:0] want, input logic [7:0] got);
    if (want !== got) begin
      n_errors++;
      $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, what, want, got);
    end
  endtask

  // result checker: oldest expectation against each accepted result
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        n_errors++;
        $display("%0t ns: result with nothing expected, expected none, got char %0h",
                 $time, out_char);
      end else begin
        head_result = expected_results.pop_front();
        cmp_field("out_char", head_result.out_char, out_char);
        cmp_field("keep_char", 8'(head_result.keep_char), 8'(out_keep_char));
        cmp_field("args_closed", 8'(head_result.args_closed), 8'(out_args_closed));
        cmp_field("list_closed", 8'(head_result.list_closed), 8'(out_list_closed));
        cmp_field("ended_open", 8'(head_result.ended_open), 8'(out_ended_open));
        cmp_field("depth_overflow", 8'(head_result.depth_overflow), 8'(out_depth_overflow));
        n_results++;
        n_args  += head_result.args_closed;
        n_lists += head_result.list_closed;
        n_open  += head_result.ended_open;
        n_ovf   += head_result.depth_overflow;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int ph;
    int goal;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_pct = SEND_IDLE[0];
    recv_pct = RECV_IDLE[0];
    foreach (dir_rows[i]) send_item(dir_rows[i].item, dir_rows[i].pinned, dir_rows[i].want);
    drain();

    // three phases: sender idles less than receiver stalls, then the reverse,
    // then full rate; the deep nesting run goes in the middle phase
    for (ph = 0; ph < 3; ph++) begin
      send_pct = SEND_IDLE[ph];
      recv_pct = RECV_IDLE[ph];
      if (ph == 1) begin
        build_deep();
        send_text();
      end
      goal = n_items + 420;
      while (n_items < goal) begin
        if ($urandom_range(0, 9) < 8) build_list();
        else build_noise();
        send_text();
      end
      drain();
    end

    // wait out any stray results before the summary
    repeat (8) @(posedge clk);
    $display("covered %0d items and %0d results, directed corners plus random lists",
             n_items, n_results);
    $display("%0d arguments, %0d lists closed, %0d open line ends, %0d depth overflows",
             n_args, n_lists, n_open, n_ovf);
    if (n_errors == 0) begin
      $display("tb_macro_argument_splitter: PASS");
    end else begin
      $display("tb_macro_argument_splitter: FAIL");
    end
    $finish;
  end

  // watchdog, far beyond the slowest correct run
  initial begin
    #5_000_000;
    $display("timeout with %0d results outstanding", expected_results.size());
    $display("tb_macro_argument_splitter: FAIL");
    $finish;
  end

endmodule
